[hw/rtl/fpsp_pkg.sv]
//------------------------------------------------------------------------------
// fpsp_pkg: shared types and constants for the format specifier parser
// Result item layout, phase codes, character classes and lookup functions.
//------------------------------------------------------------------------------
`default_nettype none

package fpsp_pkg;

    localparam int POS_BITS_DEF = 16;
    localparam int NUM_MAX_DEF  = 65535;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 104;
    localparam int OUT_TUSER_W = 2;

    localparam int FIFO_DEPTH = 4;

    localparam logic [7:0] START_CHAR_RST = 8'd37;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_H  = 8'h68;
    localparam logic [7:0] CH_LOW_L  = 8'h6C;

    localparam logic [1:0] KIND_TEXT    = 2'd0;
    localparam logic [1:0] KIND_PATTERN = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;
    localparam logic [1:0] KIND_END     = 2'd3;

    localparam logic [3:0] LEN_NONE = 4'd0;
    localparam logic [3:0] LEN_HH   = 4'd1;
    localparam logic [3:0] LEN_H    = 4'd2;
    localparam logic [3:0] LEN_L    = 4'd3;
    localparam logic [3:0] LEN_LL   = 4'd4;
    localparam logic [3:0] LEN_BIG_L = 4'd5;
    localparam logic [3:0] LEN_Z    = 4'd6;
    localparam logic [3:0] LEN_J    = 4'd7;
    localparam logic [3:0] LEN_T    = 4'd8;

    localparam logic [4:0] TYPE_NONE = 5'd19;

    localparam logic [5:0] FLAG_ZERO = 6'b001000;

    typedef enum logic [6:0] {
        PH_TEXT  = 7'b0000001,
        PH_START = 7'b0000010,
        PH_FLAGS = 7'b0000100,
        PH_WIDTH = 7'b0001000,
        PH_WDONE = 7'b0010000,
        PH_PREC  = 7'b0100000,
        PH_LEN   = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [16:0] arg_index;
        logic [5:0]         flag_bits;
        logic [15:0]        field_width;
        logic               width_from_arg;
        logic [15:0]        precision_value;
        logic               precision_from_arg;
        logic [3:0]         length_code;
        logic [4:0]         type_code;
        logic [15:0]        seg_start;
        logic [15:0]        seg_end;
        logic               last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } push_t;

    function automatic logic [4:0] type_lookup(input logic [7:0] c);
        logic [4:0] t;
        case (c)
            8'h25:   t = 5'd0;
            8'h64:   t = 5'd1;
            8'h69:   t = 5'd2;
            8'h75:   t = 5'd3;
            8'h66:   t = 5'd4;
            8'h46:   t = 5'd5;
            8'h65:   t = 5'd6;
            8'h45:   t = 5'd7;
            8'h67:   t = 5'd8;
            8'h47:   t = 5'd9;
            8'h78:   t = 5'd10;
            8'h58:   t = 5'd11;
            8'h6F:   t = 5'd12;
            8'h73:   t = 5'd13;
            8'h63:   t = 5'd14;
            8'h70:   t = 5'd15;
            8'h61:   t = 5'd16;
            8'h41:   t = 5'd17;
            8'h6E:   t = 5'd18;
            default: t = TYPE_NONE;
        endcase
        return t;
    endfunction

    function automatic logic [3:0] length_lookup(input logic [7:0] c);
        logic [3:0] l;
        case (c)
            8'h68:   l = LEN_H;
            8'h6C:   l = LEN_L;
            8'h4C:   l = LEN_BIG_L;
            8'h7A:   l = LEN_Z;
            8'h6A:   l = LEN_J;
            8'h74:   l = LEN_T;
            default: l = LEN_NONE;
        endcase
        return l;
    endfunction

    function automatic logic [5:0] flag_mask(input logic [7:0] c);
        logic [5:0] m;
        case (c)
            8'h2D:   m = 6'b000001;
            8'h2B:   m = 6'b000010;
            8'h20:   m = 6'b000100;
            8'h30:   m = 6'b001000;
            8'h27:   m = 6'b010000;
            8'h23:   m = 6'b100000;
            default: m = 6'b000000;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/fpsp_core.sv]
//------------------------------------------------------------------------------
// fpsp_core: format specifier phase machine
// Updates the parse state for one character and forms up to two result items.
//------------------------------------------------------------------------------
`default_nettype none

module fpsp_core #(
    parameter int POS_BITS = fpsp_pkg::POS_BITS_DEF,
    parameter int NUM_MAX  = fpsp_pkg::NUM_MAX_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire logic [7:0]      ch,
    input  wire logic            eot,
    input  wire logic [7:0]      start_char,
    output fpsp_pkg::push_t      push
);

    localparam int NUM_BITS = $clog2(64'(NUM_MAX) + 64'd1);
    localparam int ACC_W    = NUM_BITS + 4;

    fpsp_pkg::phase_t      phase_reg, phase_next;
    logic [NUM_BITS-1:0]   acc_reg, acc_next;
    logic                  az_reg, az_next;
    logic [5:0]            flags_reg, flags_next;
    logic [NUM_BITS-1:0]   width_reg, width_next;
    logic                  wstar_reg, wstar_next;
    logic [NUM_BITS-1:0]   prec_reg, prec_next;
    logic                  pstar_reg, pstar_next;
    logic                  argv_reg, argv_next;
    logic [NUM_BITS-1:0]   arg_reg, arg_next;
    logic [3:0]            len_reg, len_next;
    logic [POS_BITS-1:0]   sstart_reg, sstart_next;
    logic [POS_BITS-1:0]   pos_reg, pos_next;
    logic                  topen_reg, topen_next;
    logic                  disc_reg, disc_next;

    logic                  is_digit;
    logic [5:0]            fb;
    logic [NUM_BITS-1:0]   acc_operand;
    logic [NUM_BITS-1:0]   acc_value;
    logic [3:0]            len_code;
    logic [4:0]            type_code;
    logic                  go_aw;
    logic                  go_len;
    logic                  go_type;
    logic                  fail;
    fpsp_pkg::result_t     r0;
    fpsp_pkg::result_t     r1;
    logic [1:0]            n_res;

    function automatic logic [NUM_BITS-1:0] acc_digit(input logic [NUM_BITS-1:0] a,
                                                      input logic [3:0] d);
        logic [ACC_W-1:0] v;
        v = (ACC_W'(a) << 3) + (ACC_W'(a) << 1) + ACC_W'(d);
        if (v > ACC_W'(NUM_MAX))
        begin
            v = ACC_W'(NUM_MAX);
        end
        return v[NUM_BITS-1:0];
    endfunction

    function automatic logic [15:0] pos16(input logic [POS_BITS-1:0] p);
        logic [31:0] w;
        w = 32'(p);
        return w[15:0];
    endfunction

    function automatic logic [16:0] arg17(input logic [NUM_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[16:0];
    endfunction

    function automatic logic [15:0] num16(input logic [NUM_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[15:0];
    endfunction

    function automatic fpsp_pkg::result_t plain_result(input logic [1:0] kind,
                                                       input logic [15:0] s,
                                                       input logic [15:0] e);
        fpsp_pkg::result_t r;
        r = '0;
        r.kind      = kind;
        r.arg_index = '1;
        r.type_code = fpsp_pkg::TYPE_NONE;
        r.seg_start = s;
        r.seg_end   = e;
        return r;
    endfunction

    assign is_digit  = (ch >= fpsp_pkg::CH_ZERO) && (ch <= fpsp_pkg::CH_NINE);
    assign fb        = fpsp_pkg::flag_mask(ch);
    assign len_code  = fpsp_pkg::length_lookup(ch);
    assign type_code = fpsp_pkg::type_lookup(ch);

    always_comb
    begin
        if (phase_reg == fpsp_pkg::PH_PREC)
        begin
            acc_operand = prec_reg;
        end
        else if (phase_reg == fpsp_pkg::PH_FLAGS)
        begin
            acc_operand = '0;
        end
        else
        begin
            acc_operand = acc_reg;
        end
    end

    assign acc_value = acc_digit(acc_operand, ch[3:0]);

    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        az_next     = az_reg;
        flags_next  = flags_reg;
        width_next  = width_reg;
        wstar_next  = wstar_reg;
        prec_next   = prec_reg;
        pstar_next  = pstar_reg;
        argv_next   = argv_reg;
        arg_next    = arg_reg;
        len_next    = len_reg;
        sstart_next = sstart_reg;
        pos_next    = pos_reg;
        topen_next  = topen_reg;
        disc_next   = disc_reg;
        go_aw       = 1'b0;
        go_len      = 1'b0;
        go_type     = 1'b0;
        fail        = 1'b0;
        n_res       = 2'd0;
        r0          = plain_result(fpsp_pkg::KIND_END, pos16(pos_reg), pos16(pos_reg));
        r1          = plain_result(fpsp_pkg::KIND_END, pos16(pos_reg), pos16(pos_reg));

        if (eot)
        begin
            if (!disc_reg)
            begin
                if (phase_reg == fpsp_pkg::PH_TEXT)
                begin
                    if (topen_reg)
                    begin
                        r0 = plain_result(fpsp_pkg::KIND_TEXT, pos16(sstart_reg),
                                          pos16(pos_reg));
                        n_res = 2'd1;
                    end
                end
                else
                begin
                    r0 = plain_result(fpsp_pkg::KIND_ERROR, pos16(sstart_reg),
                                      pos16(pos_reg));
                    n_res = 2'd1;
                end
            end
            if (n_res == 2'd1)
            begin
                n_res = 2'd2;
            end
            else
            begin
                n_res = 2'd1;
            end
            phase_next  = fpsp_pkg::PH_TEXT;
            acc_next    = '0;
            az_next     = 1'b1;
            flags_next  = '0;
            width_next  = '0;
            wstar_next  = 1'b0;
            prec_next   = '0;
            pstar_next  = 1'b0;
            argv_next   = 1'b0;
            len_next    = fpsp_pkg::LEN_NONE;
            sstart_next = '0;
            pos_next    = '0;
            topen_next  = 1'b0;
            disc_next   = 1'b0;
        end
        else
        begin
            if (!disc_reg)
            begin
                if (phase_reg == fpsp_pkg::PH_TEXT)
                begin
                    if (ch == start_char)
                    begin
                        if (topen_reg)
                        begin
                            r0 = plain_result(fpsp_pkg::KIND_TEXT, pos16(sstart_reg),
                                              pos16(pos_reg));
                            n_res = 2'd1;
                        end
                        topen_next  = 1'b0;
                        acc_next    = '0;
                        az_next     = 1'b1;
                        flags_next  = '0;
                        width_next  = '0;
                        wstar_next  = 1'b0;
                        prec_next   = '0;
                        pstar_next  = 1'b0;
                        argv_next   = 1'b0;
                        len_next    = fpsp_pkg::LEN_NONE;
                        sstart_next = pos_reg;
                        phase_next  = fpsp_pkg::PH_START;
                    end
                    else if (!topen_reg)
                    begin
                        topen_next  = 1'b1;
                        sstart_next = pos_reg;
                    end
                end
                else
                begin
                    unique case (phase_reg)
                        fpsp_pkg::PH_START:
                        begin
                            if (is_digit)
                            begin
                                if (az_reg && (ch == fpsp_pkg::CH_ZERO))
                                begin
                                    flags_next = flags_reg | fpsp_pkg::FLAG_ZERO;
                                end
                                else
                                begin
                                    acc_next = acc_value;
                                    az_next  = 1'b0;
                                end
                            end
                            else if (ch == fpsp_pkg::CH_DOLLAR)
                            begin
                                argv_next  = 1'b1;
                                arg_next   = acc_reg;
                                flags_next = '0;
                                acc_next   = '0;
                                az_next    = 1'b1;
                                phase_next = fpsp_pkg::PH_FLAGS;
                            end
                            else if ((fb != 6'b0) && az_reg)
                            begin
                                flags_next = flags_reg | fb;
                                phase_next = fpsp_pkg::PH_FLAGS;
                            end
                            else if (ch == fpsp_pkg::CH_STAR)
                            begin
                                width_next = '0;
                                wstar_next = 1'b1;
                                phase_next = fpsp_pkg::PH_WDONE;
                            end
                            else
                            begin
                                width_next = acc_reg;
                                go_aw      = 1'b1;
                            end
                        end
                        fpsp_pkg::PH_FLAGS:
                        begin
                            if (fb != 6'b0)
                            begin
                                flags_next = flags_reg | fb;
                            end
                            else if (is_digit)
                            begin
                                acc_next   = acc_value;
                                az_next    = 1'b0;
                                phase_next = fpsp_pkg::PH_WIDTH;
                            end
                            else if (ch == fpsp_pkg::CH_STAR)
                            begin
                                width_next = '0;
                                wstar_next = 1'b1;
                                phase_next = fpsp_pkg::PH_WDONE;
                            end
                            else
                            begin
                                go_aw = 1'b1;
                            end
                        end
                        fpsp_pkg::PH_WIDTH:
                        begin
                            if (is_digit)
                            begin
                                acc_next = acc_value;
                            end
                            else if (ch == fpsp_pkg::CH_STAR)
                            begin
                                width_next = '0;
                                wstar_next = 1'b1;
                                phase_next = fpsp_pkg::PH_WDONE;
                            end
                            else
                            begin
                                width_next = acc_reg;
                                go_aw      = 1'b1;
                            end
                        end
                        fpsp_pkg::PH_WDONE:
                        begin
                            go_aw = 1'b1;
                        end
                        fpsp_pkg::PH_PREC:
                        begin
                            if (is_digit)
                            begin
                                prec_next = acc_value;
                            end
                            else if (ch == fpsp_pkg::CH_STAR)
                            begin
                                prec_next  = '0;
                                pstar_next = 1'b1;
                                phase_next = fpsp_pkg::PH_LEN;
                            end
                            else
                            begin
                                go_len = 1'b1;
                            end
                        end
                        default:
                        begin
                            go_len = 1'b1;
                        end
                    endcase

                    if (go_aw)
                    begin
                        if (ch == fpsp_pkg::CH_DOT)
                        begin
                            prec_next  = '0;
                            phase_next = fpsp_pkg::PH_PREC;
                        end
                        else
                        begin
                            go_len = 1'b1;
                        end
                    end

                    if (go_len)
                    begin
                        if (len_code == fpsp_pkg::LEN_NONE)
                        begin
                            go_type = 1'b1;
                        end
                        else
                        begin
                            phase_next = fpsp_pkg::PH_LEN;
                            if (len_reg == fpsp_pkg::LEN_NONE)
                            begin
                                len_next = len_code;
                            end
                            else if ((len_reg == fpsp_pkg::LEN_H) &&
                                     (ch == fpsp_pkg::CH_LOW_H))
                            begin
                                len_next = fpsp_pkg::LEN_HH;
                            end
                            else if ((len_reg == fpsp_pkg::LEN_L) &&
                                     (ch == fpsp_pkg::CH_LOW_L))
                            begin
                                len_next = fpsp_pkg::LEN_LL;
                            end
                            else
                            begin
                                fail = 1'b1;
                            end
                        end
                    end

                    if (go_type)
                    begin
                        if (type_code != fpsp_pkg::TYPE_NONE)
                        begin
                            r0.kind               = fpsp_pkg::KIND_PATTERN;
                            r0.arg_index          = argv_next ? arg17(arg_next) : '1;
                            r0.flag_bits          = flags_next;
                            r0.field_width        = num16(width_next);
                            r0.width_from_arg     = wstar_next;
                            r0.precision_value    = num16(prec_next);
                            r0.precision_from_arg = pstar_next;
                            r0.length_code        = len_next;
                            r0.type_code          = type_code;
                            r0.seg_start          = pos16(sstart_reg);
                            r0.seg_end            = pos16(pos_reg + POS_BITS'(1));
                            n_res                 = 2'd1;
                            phase_next            = fpsp_pkg::PH_TEXT;
                            topen_next            = 1'b0;
                            acc_next              = '0;
                            az_next               = 1'b1;
                            flags_next            = '0;
                            width_next            = '0;
                            wstar_next            = 1'b0;
                            prec_next             = '0;
                            pstar_next            = 1'b0;
                            argv_next             = 1'b0;
                            len_next              = fpsp_pkg::LEN_NONE;
                        end
                        else
                        begin
                            fail = 1'b1;
                        end
                    end

                    if (fail)
                    begin
                        r0 = plain_result(fpsp_pkg::KIND_ERROR, pos16(sstart_reg),
                                          pos16(pos_reg));
                        n_res      = 2'd1;
                        disc_next  = 1'b1;
                        phase_next = fpsp_pkg::PH_TEXT;
                    end
                end
            end
            pos_next = pos_reg + POS_BITS'(1);
        end

        if (n_res == 2'd1)
        begin
            r0.last = 1'b1;
        end
        else if (n_res == 2'd2)
        begin
            r1.last = 1'b1;
        end
    end

    always_comb
    begin
        push.count = step ? n_res : 2'd0;
        push.r0    = r0;
        push.r1    = r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= fpsp_pkg::PH_TEXT;
            acc_reg    <= '0;
            az_reg     <= 1'b1;
            flags_reg  <= '0;
            width_reg  <= '0;
            wstar_reg  <= 1'b0;
            prec_reg   <= '0;
            pstar_reg  <= 1'b0;
            argv_reg   <= 1'b0;
            arg_reg    <= '0;
            len_reg    <= fpsp_pkg::LEN_NONE;
            sstart_reg <= '0;
            pos_reg    <= '0;
            topen_reg  <= 1'b0;
            disc_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            az_reg     <= az_next;
            flags_reg  <= flags_next;
            width_reg  <= width_next;
            wstar_reg  <= wstar_next;
            prec_reg   <= prec_next;
            pstar_reg  <= pstar_next;
            argv_reg   <= argv_next;
            arg_reg    <= arg_next;
            len_reg    <= len_next;
            sstart_reg <= sstart_next;
            pos_reg    <= pos_next;
            topen_reg  <= topen_next;
            disc_reg   <= disc_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/fpsp_result_fifo.sv]
//------------------------------------------------------------------------------
// fpsp_result_fifo: result item queue
// Takes up to two result items per cycle and hands them out one at a time.
//------------------------------------------------------------------------------
`default_nettype none

module fpsp_result_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire fpsp_pkg::push_t push,
    input  wire logic           pop,
    output fpsp_pkg::result_t   head,
    output logic                not_empty,
    output logic                room_two
);

    localparam int PTR_BITS = $clog2(fpsp_pkg::FIFO_DEPTH);
    localparam int CNT_BITS = PTR_BITS + 1;

    fpsp_pkg::result_t   mem_reg [fpsp_pkg::FIFO_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic                do_pop;

    assign not_empty = (count_reg != '0);
    assign room_two  = (count_reg <= CNT_BITS'(fpsp_pkg::FIFO_DEPTH - 2));
    assign head      = mem_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_reg + PTR_BITS'(1)] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_BITS'(push.count);
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_BITS'(1);
            end
            count_reg <= count_reg + CNT_BITS'(push.count) - CNT_BITS'(do_pop);
        end
    end

endmodule

`default_nettype wire

[hw/rtl/printf_format_spec_parser.sv]
//------------------------------------------------------------------------------
// printf_format_spec_parser: format text splitter
// Cuts a format text, one character per item, into text runs and patterns.
//------------------------------------------------------------------------------
//  Channel | Direction | Handshake        | Content
//  s_*     | in        | tvalid / tready  | tdata: ch; tlast: end_of_text
//  m_*     | out       | tvalid / tready  | tdata: parsed fields; tuser: kind;
//          |           |                  | tlast: last result of an item
//  cfg_*   | in        | cfg_wr_en        | cfg_wr_data: start_char
//
//  An item enters an input register and is parsed from there into a
//  four-entry result queue, whose head is offered on m_*. One item per
//  cycle is taken while the queue has room for two results; an end of text
//  that closes a segment gives two results, which leave the queue one at a
//  time. Reset clears the parse state, the queue and start_char to '%'.
//------------------------------------------------------------------------------
`default_nettype none

module printf_format_spec_parser #(
    parameter int POS_BITS = fpsp_pkg::POS_BITS_DEF,
    parameter int NUM_MAX  = fpsp_pkg::NUM_MAX_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [fpsp_pkg::IN_TDATA_W-1:0]    s_tdata,   // ch
    input  wire logic                               s_tlast,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // arg_index, flag_bits, field_width, width_from_arg, precision_value,
    // precision_from_arg, length_code, type_code, seg_start, seg_end, zeros
    output logic [fpsp_pkg::OUT_TDATA_W-1:0]        m_tdata,
    output logic [fpsp_pkg::OUT_TUSER_W-1:0]        m_tuser,   // kind
    output logic                                    m_tlast,
    input  wire logic                               cfg_wr_en,
    input  wire logic [7:0]                         cfg_wr_data
);

    logic              in_valid_reg;
    logic [7:0]        in_ch_reg;
    logic              in_eot_reg;
    logic [7:0]        start_char_reg;
    logic              step;
    logic              room_two;
    logic              not_empty;
    fpsp_pkg::push_t   push;
    fpsp_pkg::result_t head;

    assign step     = in_valid_reg && room_two;
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            start_char_reg <= fpsp_pkg::START_CHAR_RST;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (cfg_wr_en)
            begin
                start_char_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_ch_reg  <= s_tdata;
            in_eot_reg <= s_tlast;
        end
    end

    fpsp_core #(
        .POS_BITS (POS_BITS),
        .NUM_MAX  (NUM_MAX)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .ch         (in_ch_reg),
        .eot        (in_eot_reg),
        .start_char (start_char_reg),
        .push       (push)
    );

    fpsp_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (m_tready),
        .head      (head),
        .not_empty (not_empty),
        .room_two  (room_two)
    );

    assign m_tvalid = not_empty;
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;
    assign m_tdata  = {6'b0, head.seg_end, head.seg_start, head.type_code,
                       head.length_code, head.precision_from_arg, head.precision_value,
                       head.width_from_arg, head.field_width, head.flag_bits,
                       head.arg_index};

endmodule

`default_nettype wire

[verif/testbench.sv]
//------------------------------------------------------------------------------
// testbench: self-checking bench for printf_format_spec_parser
// Streams directed and random format texts into the parser under several start
// characters. A scoreboard predicts every text run, pattern, error and
// end-of-text result and compares them field by field with the output stream.
// Both stream sides pause at random.
//------------------------------------------------------------------------------
`default_nettype none

module testbench;
    import fpsp_pkg::*;

    localparam logic [5:0] FL_LEFT  = 6'b000001;
    localparam logic [5:0] FL_PLUS  = 6'b000010;
    localparam logic [5:0] FL_SPACE = 6'b000100;
    localparam logic [5:0] FL_GROUP = 6'b010000;
    localparam logic [5:0] FL_ALT   = 6'b100000;

    localparam logic signed [16:0] NO_ARG = -17'sd1;

    localparam string TYPE_LETTERS   = "%diufFeEgGxXoscpaAn";
    localparam string LENGTH_LETTERS = "hlLzjt";
    localparam string FLAG_LETTERS   = "-+ 0'#";

    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_ITEMS   = 200;
    localparam int REPORT_MAX    = 10;

    class segment_tracker;
        logic [7:0]  opener;
        phase_t      ph;
        int unsigned accum;
        bit          all_zero;
        logic [5:0]  flags;
        int unsigned width_num;
        bit          width_star;
        int unsigned prec_num;
        bit          prec_star;
        int          arg_num;
        logic [3:0]  len_code;
        logic [15:0] seg_begin;
        logic [15:0] pos;
        bit          in_text;
        bit          dropping;
        result_t     expected_segments[$];
        result_t     fresh[$];
        int          mismatches;
        int          kind_seen[4];

        function new();
            opener = START_CHAR_RST;
            clear_spec();
            ph = PH_TEXT;
            seg_begin = '0;
            pos = '0;
            in_text = 1'b0;
            dropping = 1'b0;
            mismatches = 0;
            foreach (kind_seen[k])
                kind_seen[k] = 0;
        endfunction

        function void clear_spec();
            accum = 0;
            all_zero = 1'b1;
            flags = '0;
            width_num = 0;
            width_star = 1'b0;
            prec_num = 0;
            prec_star = 1'b0;
            arg_num = -1;
            len_code = LEN_NONE;
        endfunction

        function void push_segment(logic [1:0] kind, bit full, logic [4:0] tcode,
                                   logic [15:0] s, logic [15:0] e);
            result_t r;
            r = '0;
            r.kind = kind;
            r.arg_index = NO_ARG;
            if (full)
            begin
                r.arg_index = arg_num[16:0];
                r.flag_bits = flags;
                r.field_width = width_num[15:0];
                r.width_from_arg = width_star;
                r.precision_value = prec_num[15:0];
                r.precision_from_arg = prec_star;
                r.length_code = len_code;
            end
            r.type_code = tcode;
            r.seg_start = s;
            r.seg_end = e;
            fresh.push_back(r);
        endfunction

        function int unsigned add_digit(int unsigned acc, logic [7:0] c);
            longint unsigned v;
            v = 64'(acc) * 64'd10 + 64'(c - CH_ZERO);
            if (v > 64'(NUM_MAX_DEF))
                v = 64'(NUM_MAX_DEF);
            return v[31:0];
        endfunction

        function logic [5:0] flag_of(logic [7:0] c);
            case (c)
                "-":     return FL_LEFT;
                "+":     return FL_PLUS;
                " ":     return FL_SPACE;
                "0":     return FLAG_ZERO;
                "'":     return FL_GROUP;
                "#":     return FL_ALT;
                default: return '0;
            endcase
        endfunction

        function void fail_spec();
            push_segment(KIND_ERROR, 1'b0, TYPE_NONE, seg_begin, pos);
            dropping = 1'b1;
            ph = PH_TEXT;
        endfunction

        function void finish_type(logic [7:0] c);
            int i;
            for (i = 0; i < TYPE_LETTERS.len(); i++)
            begin
                if (TYPE_LETTERS[i] == c)
                begin
                    push_segment(KIND_PATTERN, 1'b1, 5'(i), seg_begin, pos + 16'd1);
                    ph = PH_TEXT;
                    in_text = 1'b0;
                    clear_spec();
                    return;
                end
            end
            fail_spec();
        endfunction

        function void length_char(logic [7:0] c);
            logic [3:0] code;
            case (c)
                "h":     code = LEN_H;
                "l":     code = LEN_L;
                "L":     code = LEN_BIG_L;
                "z":     code = LEN_Z;
                "j":     code = LEN_J;
                "t":     code = LEN_T;
                default: code = LEN_NONE;
            endcase
            if (code == LEN_NONE)
            begin
                finish_type(c);
                return;
            end
            ph = PH_LEN;
            if (len_code == LEN_NONE)
                len_code = code;
            else if (len_code == LEN_H && code == LEN_H)
                len_code = LEN_HH;
            else if (len_code == LEN_L && code == LEN_L)
                len_code = LEN_LL;
            else
                fail_spec();
        endfunction

        function void after_width(logic [7:0] c);
            if (c == CH_DOT)
            begin
                prec_num = 0;
                ph = PH_PREC;
            end
            else
                length_char(c);
        endfunction

        function void star_width();
            width_num = 0;
            width_star = 1'b1;
            ph = PH_WDONE;
        endfunction

        function void spec_char(logic [7:0] c);
            bit digit;
            logic [5:0] fm;
            digit = (c >= CH_ZERO && c <= CH_NINE);
            fm = flag_of(c);
            case (ph)
                PH_START:
                begin
                    if (digit)
                    begin
                        if (all_zero && c == CH_ZERO)
                            flags |= FLAG_ZERO;
                        else
                        begin
                            accum = add_digit(accum, c);
                            all_zero = 1'b0;
                        end
                    end
                    else if (c == CH_DOLLAR)
                    begin
                        arg_num = int'(accum);
                        flags = '0;
                        accum = 0;
                        all_zero = 1'b1;
                        ph = PH_FLAGS;
                    end
                    else if (fm != '0 && all_zero)
                    begin
                        flags |= fm;
                        ph = PH_FLAGS;
                    end
                    else if (c == CH_STAR)
                        star_width();
                    else
                    begin
                        width_num = accum;
                        after_width(c);
                    end
                end
                PH_FLAGS:
                begin
                    if (fm != '0)
                        flags |= fm;
                    else if (digit)
                    begin
                        accum = add_digit(0, c);
                        all_zero = 1'b0;
                        ph = PH_WIDTH;
                    end
                    else if (c == CH_STAR)
                        star_width();
                    else
                        after_width(c);
                end
                PH_WIDTH:
                begin
                    if (digit)
                        accum = add_digit(accum, c);
                    else if (c == CH_STAR)
                        star_width();
                    else
                    begin
                        width_num = accum;
                        after_width(c);
                    end
                end
                PH_WDONE:
                    after_width(c);
                PH_PREC:
                begin
                    if (digit)
                        prec_num = add_digit(prec_num, c);
                    else if (c == CH_STAR)
                    begin
                        prec_num = 0;
                        prec_star = 1'b1;
                        ph = PH_LEN;
                    end
                    else
                        length_char(c);
                end
                default:
                    length_char(c);
            endcase
        endfunction

        function void take_char(logic [7:0] c, logic eot);
            result_t r;
            fresh.delete();
            if (eot)
            begin
                if (!dropping)
                begin
                    if (ph == PH_TEXT)
                    begin
                        if (in_text)
                            push_segment(KIND_TEXT, 1'b0, TYPE_NONE, seg_begin, pos);
                    end
                    else
                        push_segment(KIND_ERROR, 1'b0, TYPE_NONE, seg_begin, pos);
                end
                push_segment(KIND_END, 1'b0, TYPE_NONE, pos, pos);
                ph = PH_TEXT;
                clear_spec();
                seg_begin = '0;
                pos = '0;
                in_text = 1'b0;
                dropping = 1'b0;
            end
            else
            begin
                if (!dropping)
                begin
                    if (ph == PH_TEXT)
                    begin
                        if (c == opener)
                        begin
                            if (in_text)
                                push_segment(KIND_TEXT, 1'b0, TYPE_NONE, seg_begin, pos);
                            in_text = 1'b0;
                            clear_spec();
                            seg_begin = pos;
                            ph = PH_START;
                        end
                        else if (!in_text)
                        begin
                            in_text = 1'b1;
                            seg_begin = pos;
                        end
                    end
                    else
                        spec_char(c);
                end
                pos = pos + 16'd1;
            end
            if (fresh.size() > 0)
            begin
                r = fresh.pop_back();
                r.last = 1'b1;
                fresh.push_back(r);
            end
            foreach (fresh[i])
                expected_segments.push_back(fresh[i]);
        endfunction

        function string describe(result_t r);
            return $sformatf({"kind=%0d arg=%0d flags=%b width=%0d/%0d prec=%0d/%0d",
                              " len=%0d type=%0d seg=%0d..%0d last=%0d"},
                             r.kind, r.arg_index, r.flag_bits, r.field_width,
                             r.width_from_arg, r.precision_value, r.precision_from_arg,
                             r.length_code, r.type_code, r.seg_start, r.seg_end, r.last);
        endfunction

        function void report(string what, result_t want, result_t got, bit have_want);
            mismatches++;
            if (mismatches <= REPORT_MAX)
            begin
                $display("mismatch: %s", what);
                if (have_want)
                    $display("  expected %s", describe(want));
                $display("  actual   %s", describe(got));
            end
        endfunction

        function void match_segment(logic [OUT_TDATA_W-1:0] tdata,
                                    logic [OUT_TUSER_W-1:0] tuser, logic tlast);
            result_t got;
            result_t want;
            string bad;
            got.kind = tuser;
            got.arg_index = tdata[16:0];
            got.flag_bits = tdata[22:17];
            got.field_width = tdata[38:23];
            got.width_from_arg = tdata[39];
            got.precision_value = tdata[55:40];
            got.precision_from_arg = tdata[56];
            got.length_code = tdata[60:57];
            got.type_code = tdata[65:61];
            got.seg_start = tdata[81:66];
            got.seg_end = tdata[97:82];
            got.last = tlast;
            kind_seen[got.kind]++;
            if (expected_segments.size() == 0)
            begin
                report("result with no item waiting for it", got, got, 1'b0);
                return;
            end
            want = expected_segments.pop_front();
            bad = "";
            if (got.kind != want.kind)
                bad = {bad, " kind"};
            if (got.arg_index != want.arg_index)
                bad = {bad, " arg_index"};
            if (got.flag_bits != want.flag_bits)
                bad = {bad, " flag_bits"};
            if (got.field_width != want.field_width)
                bad = {bad, " field_width"};
            if (got.width_from_arg != want.width_from_arg)
                bad = {bad, " width_from_arg"};
            if (got.precision_value != want.precision_value)
                bad = {bad, " precision_value"};
            if (got.precision_from_arg != want.precision_from_arg)
                bad = {bad, " precision_from_arg"};
            if (got.length_code != want.length_code)
                bad = {bad, " length_code"};
            if (got.type_code != want.type_code)
                bad = {bad, " type_code"};
            if (got.seg_start != want.seg_start)
                bad = {bad, " seg_start"};
            if (got.seg_end != want.seg_end)
                bad = {bad, " seg_end"};
            if (got.last != want.last)
                bad = {bad, " last"};
            if (tdata[OUT_TDATA_W-1:98] != '0)
                bad = {bad, " padding"};
            if (bad != "")
                report({"fields differ:", bad}, want, got, 1'b1);
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic                   m_tlast;
    logic                   cfg_wr_en = 1'b0;
    logic [7:0]             cfg_wr_data = '0;

    segment_tracker sb = new();
    logic [7:0]     fmt_chars[$];
    int             items_sent = 0;
    int             formats_sent = 0;
    int             openers_used = 0;
    int             idle_cycles = 0;
    int             rx_hold = 0;
    bit             tx_calm = 1'b0;
    bit             rx_calm = 1'b0;

    printf_format_spec_parser dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit chance(int percent);
        return $urandom_range(0, 99) < percent;
    endfunction

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int digit_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        return $urandom_range(5, 6);
    endfunction

    function automatic void put_str(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            fmt_chars.push_back(s[i]);
    endfunction

    function automatic void put_digits(int n);
        repeat (n)
            fmt_chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    function automatic logic [7:0] text_char();
        logic [7:0] c;
        do
        begin
            if (chance(85))
                c = 8'($urandom_range(32, 126));
            else
                c = 8'($urandom_range(0, 255));
        end
        while (c == sb.opener);
        return c;
    endfunction

    function automatic void add_pattern(bit cut);
        int mark;
        int pick;
        int n;
        mark = fmt_chars.size();
        fmt_chars.push_back(sb.opener);
        if (chance(20))
        begin
            put_digits(digit_count());
            fmt_chars.push_back(CH_DOLLAR);
        end
        repeat ($urandom_range(0, 3))
            fmt_chars.push_back(FLAG_LETTERS[$urandom_range(0, FLAG_LETTERS.len() - 1)]);
        pick = $urandom_range(0, 9);
        if (pick < 6)
            put_digits(digit_count());
        else if (pick < 8)
            fmt_chars.push_back(CH_STAR);
        else if (pick == 8)
        begin
            put_digits($urandom_range(1, 3));
            fmt_chars.push_back(CH_STAR);
        end
        if (chance(40))
        begin
            fmt_chars.push_back(CH_DOT);
            pick = $urandom_range(0, 8);
            if (pick < 6)
                put_digits(digit_count());
            else if (pick < 8)
                fmt_chars.push_back(CH_STAR);
            else
            begin
                put_digits($urandom_range(1, 3));
                fmt_chars.push_back(CH_STAR);
            end
        end
        if (chance(40))
        begin
            pick = $urandom_range(0, LENGTH_LETTERS.len() - 1);
            fmt_chars.push_back(LENGTH_LETTERS[pick]);
            if ((LENGTH_LETTERS[pick] == CH_LOW_H || LENGTH_LETTERS[pick] == CH_LOW_L)
                && chance(40))
                fmt_chars.push_back(LENGTH_LETTERS[pick]);
        end
        if (chance(6))
            fmt_chars.push_back(LENGTH_LETTERS[$urandom_range(0, LENGTH_LETTERS.len() - 1)]);
        if (chance(88))
            fmt_chars.push_back(TYPE_LETTERS[$urandom_range(0, TYPE_LETTERS.len() - 1)]);
        else
            fmt_chars.push_back(8'($urandom_range(0, 255)));
        if (cut)
        begin
            n = $urandom_range(1, fmt_chars.size() - mark - 1);
            repeat (n)
                void'(fmt_chars.pop_back());
        end
    endfunction

    task automatic send_item(input logic [7:0] c, input logic eot);
        int gap;
        gap = tx_calm ? 0 : idle_length();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eot;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.take_char(c, eot);
        items_sent++;
    endtask

    task automatic send_format();
        foreach (fmt_chars[i])
            send_item(fmt_chars[i], 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
        formats_sent++;
    endtask

    task automatic run_random_format();
        int segs;
        int k;
        fmt_chars.delete();
        if (chance(8))
        begin
            repeat ($urandom_range(1, 12))
                fmt_chars.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            segs = $urandom_range(1, 5);
            for (k = 0; k < segs; k++)
            begin
                if (chance(45))
                begin
                    repeat ($urandom_range(1, 6))
                        fmt_chars.push_back(text_char());
                end
                else
                    add_pattern(k == segs - 1 && chance(12));
            end
        end
        send_format();
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.expected_segments.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_opener(input logic [7:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.opener = v;
        openers_used++;
    endtask

    always @(posedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold = rx_hold - 1;
            m_tready <= 1'b0;
        end
        else if (!rx_calm && chance(25))
        begin
            rx_hold = idle_length();
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.match_segment(m_tdata, m_tuser, m_tlast);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        logic [7:0] openers[$];
        int target;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // An end of text with nothing open, then one dense pattern and a few
        // awkward ones under the reset start character.
        send_item(8'h00, 1'b1);
        fmt_chars.delete();
        fmt_chars.push_back(8'h00);
        fmt_chars.push_back(8'hFF);
        put_str("%12$-+ 0'#*.99999hhd%$5*d%5");
        send_format();

        openers = '{8'h00, 8'hFF, "#", "d", 8'($urandom_range(1, 254)), START_CHAR_RST};
        foreach (openers[p])
        begin
            wait_drained();
            write_opener(openers[p]);
            tx_calm = (p == 2);
            rx_calm = (p == 3);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                run_random_format();
                if (chance(4))
                    wait_drained();
            end
        end

        wait_drained();
        $display("Sent %0d characters in %0d format texts under %0d start characters,",
                 items_sent, formats_sent, openers_used);
        $display("checked %0d text runs, %0d patterns, %0d errors and %0d ends of text.",
                 sb.kind_seen[KIND_TEXT], sb.kind_seen[KIND_PATTERN],
                 sb.kind_seen[KIND_ERROR], sb.kind_seen[KIND_END]);
        if (sb.expected_segments.size() != 0)
            $display("%0d expected results never arrived", sb.expected_segments.size());
        if (sb.mismatches == 0 && sb.expected_segments.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
